[design/mpeg1_block_dequantizer_macros.svh]
// Assertion macros for the block dequantizer.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef MPEG1_BLOCK_DEQUANTIZER_MACROS_SVH
`define MPEG1_BLOCK_DEQUANTIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset.
`define MBDQ_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mbdq: invariant violated");

// Check that a trigger implies a consequence in the same cycle.
`define MBDQ_ASSERT_SAME(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("mbdq: same-cycle implication violated");

// Check that a trigger implies a consequence in the next cycle.
`define MBDQ_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("mbdq: next-cycle implication violated");

`else

`define MBDQ_ASSERT_ALWAYS(lbl, cond)
`define MBDQ_ASSERT_SAME(lbl, trig, cons)
`define MBDQ_ASSERT_NEXT(lbl, trig, cons)

`endif

`endif

[design/mbdq_pkg.sv]
`default_nettype none

package mbdq_pkg;

    // Item operation codes
    typedef enum logic [2:0] {
        OP_INTRA_DC        = 3'd0,
        OP_START_NONINTRA  = 3'd1,
        OP_COEF            = 3'd2,
        OP_LOAD_INTRA_W    = 3'd3,
        OP_LOAD_NONINTRA_W = 3'd4,
        OP_SET_PRED        = 3'd5
    } op_t;

    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 32;
    localparam int unsigned COEF_W     = 19;
    localparam int unsigned MAG_W      = 18;
    localparam int unsigned PARTIAL_W  = 15;
    localparam int unsigned PRODUCT_W  = 23;
    localparam int unsigned SCALED_W   = 20;

    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    // Predictor selects
    localparam logic [1:0] PRED_LUMA = 2'd0;
    localparam logic [1:0] PRED_CB   = 2'd1;
    localparam logic [1:0] PRED_CR   = 2'd2;

    // Zigzag scan order: scan index to natural index
    localparam logic [5:0] SCAN_ORDER [64] = '{
        6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
        6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
        6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
        6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
    };

    // Unpacked input beat
    typedef struct packed {
        op_t                operation;
        logic [2:0]         component;
        logic signed [8:0]  dc_diff;
        logic [5:0]         run;
        logic [8:0]         level_magnitude;
        logic               level_sign;
        logic [4:0]         quant_scale;
        logic [5:0]         weight_index;
        logic [7:0]         weight_value;
        logic signed [15:0] predictor_value;
    } in_fields_t;

    // Classified work item handed from front to back
    typedef struct packed {
        logic              is_dc;
        logic              err;
        logic [5:0]        position;
        logic [COEF_W-1:0] dc_coef;
        logic [8:0]        level;
        logic              neg;
        logic [4:0]        qs;
        logic              intra;
        logic [7:0]        weight;
    } work_t;

endpackage

`default_nettype wire

[design/mbdq_front.sv]
`default_nettype none

module mbdq_front
    import mbdq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_fields_t in_fields,
    output logic            work_valid,
    output work_t           work,
    input  wire logic       work_ready
);

    logic        accept;
    logic        push;
    logic        valid_reg, valid_next;
    logic [6:0]  scan_pos_reg, scan_pos_next;
    logic        intra_reg, intra_next;
    logic [15:0] pred_reg [3];
    logic [15:0] pred_next [3];
    work_t       item_reg, item_next;

    logic [7:0]  intra_w_mem    [64];
    logic [7:0]  nonintra_w_mem [64];
    logic [7:0]  intra_rd_reg;
    logic [7:0]  nonintra_rd_reg;

    logic [7:0]  pos_sum;
    logic        overflow;
    logic [5:0]  zz_index;
    logic [1:0]  pred_sel;
    logic [15:0] dc_sum;

    assign push     = valid_reg && work_ready;
    assign in_ready = !valid_reg || work_ready;
    assign accept   = in_valid && in_ready;

    // Advance scan position and map through zigzag
    assign pos_sum  = {1'b0, scan_pos_reg} + {2'b00, in_fields.run};
    assign overflow = (pos_sum > 8'd63);
    assign zz_index = SCAN_ORDER[pos_sum[5:0]];

    // Pick predictor by component and add the difference
    always_comb
    begin
        if (in_fields.component < 3'd4)
            pred_sel = PRED_LUMA;
        else if (in_fields.component == 3'd4)
            pred_sel = PRED_CB;
        else
            pred_sel = PRED_CR;
    end

    assign dc_sum = pred_reg[pred_sel] + {{7{in_fields.dc_diff[8]}}, in_fields.dc_diff};

    // Classify the beat and update front state
    always_comb
    begin
        scan_pos_next = scan_pos_reg;
        intra_next    = intra_reg;
        pred_next     = pred_reg;
        item_next     = item_reg;
        valid_next    = push ? 1'b0 : valid_reg;
        if (accept)
        begin
            unique case (in_fields.operation)
                OP_INTRA_DC:
                begin
                    pred_next[pred_sel] = dc_sum;
                    intra_next          = 1'b1;
                    scan_pos_next       = 7'd1;
                    valid_next          = 1'b1;
                    item_next           = '0;
                    item_next.is_dc     = 1'b1;
                    item_next.dc_coef   = {dc_sum, 3'b000};
                end
                OP_START_NONINTRA:
                begin
                    intra_next    = 1'b0;
                    scan_pos_next = 7'd0;
                end
                OP_COEF:
                begin
                    valid_next     = 1'b1;
                    item_next      = '0;
                    item_next.level = in_fields.level_magnitude;
                    item_next.neg   = in_fields.level_sign;
                    item_next.qs    = in_fields.quant_scale;
                    item_next.intra = intra_reg;
                    if (overflow)
                    begin
                        scan_pos_next = 7'd64;
                        item_next.err = 1'b1;
                    end
                    else
                    begin
                        scan_pos_next      = pos_sum[6:0] + 7'd1;
                        item_next.position = zz_index;
                    end
                end
                OP_SET_PRED:
                begin
                    pred_next[0] = in_fields.predictor_value;
                    pred_next[1] = in_fields.predictor_value;
                    pred_next[2] = in_fields.predictor_value;
                end
                default:
                begin
                    // weight loads write only the weight memories; unused codes touch no front state
                end
            endcase
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            scan_pos_reg <= '0;
            intra_reg    <= 1'b0;
            pred_reg     <= '{default: '0};
        end
        else
        begin
            valid_reg    <= valid_next;
            scan_pos_reg <= scan_pos_next;
            intra_reg    <= intra_next;
            pred_reg     <= pred_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    // Weight memories: write on load, registered read on coefficient
    always_ff @(posedge clk)
    begin
        if (accept && in_fields.operation == OP_LOAD_INTRA_W)
            intra_w_mem[in_fields.weight_index] <= in_fields.weight_value;
        if (accept && in_fields.operation == OP_COEF)
            intra_rd_reg <= intra_w_mem[zz_index];
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_fields.operation == OP_LOAD_NONINTRA_W)
            nonintra_w_mem[in_fields.weight_index] <= in_fields.weight_value;
        if (accept && in_fields.operation == OP_COEF)
            nonintra_rd_reg <= nonintra_w_mem[zz_index];
    end

    // Attach the weight of the current mode
    always_comb
    begin
        work        = item_reg;
        work.weight = item_reg.intra ? intra_rd_reg : nonintra_rd_reg;
    end

    assign work_valid = valid_reg;

endmodule

`default_nettype wire

[design/mbdq_fifo.sv]
`default_nettype none

module mbdq_fifo
    import mbdq_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire work_t push_item,
    output logic       full,
    input  wire logic  pop,
    output work_t      pop_item,
    output logic       empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    work_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == DEPTH_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

[design/mbdq_back.sv]
`default_nettype none

module mbdq_back
    import mbdq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         work_valid,
    input  wire work_t        work,
    output logic              work_pop,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [5:0]        out_position,
    output logic [COEF_W-1:0] out_coefficient,
    output logic              out_error
);

    // Stage A: level term times quantiser scale
    logic                 a_valid_reg;
    logic                 a_is_dc_reg;
    logic                 a_err_reg;
    logic [5:0]           a_pos_reg;
    logic [COEF_W-1:0]    a_dc_reg;
    logic                 a_neg_reg;
    logic                 a_intra_reg;
    logic [PARTIAL_W-1:0] a_partial_reg;
    logic [7:0]           a_weight_reg;

    // Output register
    logic                 o_valid_reg;
    logic [5:0]           o_pos_reg, o_pos_next;
    logic [COEF_W-1:0]    o_coef_reg, o_coef_next;
    logic                 o_err_reg, o_err_next;

    logic                 o_advance;
    logic                 a_advance;
    logic [9:0]           lev_term;
    logic [PARTIAL_W-1:0] partial_next;
    logic [PRODUCT_W-1:0] product;
    logic [SCALED_W-1:0]  scaled;
    logic [SCALED_W-1:0]  odd_mag;
    logic [MAG_W-1:0]     sat_mag;

    assign o_advance = !o_valid_reg || out_ready;
    assign a_advance = !a_valid_reg || o_advance;
    assign work_pop  = work_valid && a_advance;

    // Intra uses the level, non-intra uses 2*level+1
    assign lev_term     = work.intra ? {1'b0, work.level} : {work.level, 1'b1};
    assign partial_next = PARTIAL_W'(lev_term) * PARTIAL_W'(work.qs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_advance)
            a_valid_reg <= work_valid;
    end

    always_ff @(posedge clk)
    begin
        if (work_pop)
        begin
            a_is_dc_reg   <= work.is_dc;
            a_err_reg     <= work.err;
            a_pos_reg     <= work.position;
            a_dc_reg      <= work.dc_coef;
            a_neg_reg     <= work.neg;
            a_intra_reg   <= work.intra;
            a_partial_reg <= partial_next;
            a_weight_reg  <= work.weight;
        end
    end

    // Weight product, scale shift, force odd, saturate, sign; DC and error items override
    always_comb
    begin
        product = PRODUCT_W'(a_partial_reg) * PRODUCT_W'(a_weight_reg);
        scaled  = a_intra_reg ? product[PRODUCT_W-1:3] : {1'b0, product[PRODUCT_W-1:4]};
        odd_mag = (scaled == '0) ? '0 : ((scaled - SCALED_W'(1)) | SCALED_W'(1));
        sat_mag = (odd_mag > SCALED_W'(MAG_MAX)) ? MAG_MAX : odd_mag[MAG_W-1:0];

        o_pos_next  = a_pos_reg;
        o_err_next  = a_err_reg;
        o_coef_next = a_neg_reg ? (COEF_W'(0) - {1'b0, sat_mag}) : {1'b0, sat_mag};
        if (a_err_reg)
        begin
            o_pos_next  = '0;
            o_coef_next = '0;
        end
        else if (a_is_dc_reg)
        begin
            o_pos_next  = '0;
            o_coef_next = a_dc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (o_advance)
            o_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (o_advance && a_valid_reg)
        begin
            o_pos_reg  <= o_pos_next;
            o_coef_reg <= o_coef_next;
            o_err_reg  <= o_err_next;
        end
    end

    assign out_valid       = o_valid_reg;
    assign out_position    = o_pos_reg;
    assign out_coefficient = o_coef_reg;
    assign out_error       = o_err_reg;

endmodule

`default_nettype wire

[design/mpeg1_block_dequantizer.sv]
// Channel  | Dir | Beat carries
// ---------+-----+----------------------------------------------------------
// s_axis   | in  | one block item: operation in tuser, fields in tdata
// m_axis   | out | one coefficient: position and value in tdata, error in tuser
//
// One item is taken per cycle while s_axis_tready is high; a beat that yields a
// coefficient reaches m_axis through the front register, queue, multiply stage
// and output register in that order, the first loading on acceptance.
// Loads, mode starts and predictor writes finish at acceptance and give no beat.
// The queue lets the front keep taking beats while m_axis stalls; s_axis_tready
// drops once the queue and front register are full. Reset clears the DC
// predictors, scan position and mode; weight memories hold no reset value.
`default_nettype none

`include "mpeg1_block_dequantizer_macros.svh"

module mpeg1_block_dequantizer
    import mbdq_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // component[2:0], dc_diff[11:3], run[17:12], level_magnitude[26:18],
    // level_sign[27], quant_scale[32:28], weight_index[38:33],
    // weight_value[46:39], predictor_value[62:47], zero pad [63]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // operation[2:0]
    input  wire logic [2:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // position[5:0], coefficient[24:6], zero pad [31:25]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // error[0]
    output logic [0:0]                 m_axis_tuser
);

    in_fields_t        in_fields;
    logic              front_valid;
    work_t             front_work;
    logic              fifo_full;
    logic              fifo_empty;
    work_t             fifo_item;
    logic              fifo_pop;
    logic [5:0]        out_position;
    logic [COEF_W-1:0] out_coefficient;
    logic              out_error;

    // Unpack the input beat
    always_comb
    begin
        in_fields.operation       = op_t'(s_axis_tuser);
        in_fields.component       = s_axis_tdata[2:0];
        in_fields.dc_diff         = s_axis_tdata[11:3];
        in_fields.run             = s_axis_tdata[17:12];
        in_fields.level_magnitude = s_axis_tdata[26:18];
        in_fields.level_sign      = s_axis_tdata[27];
        in_fields.quant_scale     = s_axis_tdata[32:28];
        in_fields.weight_index    = s_axis_tdata[38:33];
        in_fields.weight_value    = s_axis_tdata[46:39];
        in_fields.predictor_value = s_axis_tdata[62:47];
    end

    mbdq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_fields  (in_fields),
        .work_valid (front_valid),
        .work       (front_work),
        .work_ready (!fifo_full)
    );

    mbdq_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_item (front_work),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .pop_item  (fifo_item),
        .empty     (fifo_empty)
    );

    mbdq_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .work_valid      (!fifo_empty),
        .work            (fifo_item),
        .work_pop        (fifo_pop),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_position    (out_position),
        .out_coefficient (out_coefficient),
        .out_error       (out_error)
    );

    // Pack the output beat
    assign m_axis_tdata = {{(OUT_DATA_W - COEF_W - 6){1'b0}}, out_coefficient, out_position};
    assign m_axis_tuser = out_error;

    // An overflow beat carries neither position nor value
    `MBDQ_ASSERT_SAME(a_err_beat_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[24:0] == '0)

    // The queue cannot be full and empty at once
    `MBDQ_ASSERT_ALWAYS(a_fifo_sane, !(fifo_full && fifo_empty))

    // A DC or coefficient beat lands in the front register
    `MBDQ_ASSERT_NEXT(a_front_load, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_INTRA_DC || s_axis_tuser == OP_COEF), front_valid)

endmodule

`default_nettype wire

[bench/mpeg1_block_dequantizer_tb.sv]
module mpeg1_block_dequantizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbdq_pkg::*;

    // Operation codes the block leaves unused
    localparam logic [2:0] OP_RESERVED_6 = 3'd6;
    localparam logic [2:0] OP_RESERVED_7 = 3'd7;

    // Component numbers that pick the chroma predictors
    localparam logic [2:0] COMP_CB = 3'd4;
    localparam logic [2:0] COMP_CR = 3'd5;

    localparam logic [6:0]  SCAN_END     = 7'd64;
    localparam int unsigned MAG_LIMIT    = 262143;
    localparam int          IDLE_PCT     = 36;
    localparam int          RANDOM_ITEMS = 540;
    localparam int          STEADY_ITEMS = 150;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 300000;

    typedef struct {
        logic [2:0]         op;
        logic [2:0]         component;
        logic signed [8:0]  dc_diff;
        logic [5:0]         run;
        logic [8:0]         level_mag;
        logic               level_neg;
        logic [4:0]         qscale;
        logic [5:0]         w_index;
        logic [7:0]         w_value;
        logic signed [15:0] pred_value;
    } blk_item_t;

    typedef struct {
        logic [5:0]         position;
        logic signed [18:0] coefficient;
        logic               error;
    } coef_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [2:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    // Mirror of the block state
    logic [15:0] dc_pred [3];
    logic [6:0]  scan_pos;
    logic        intra_blk;
    logic [7:0]  intra_w [64];
    logic [7:0]  inter_w [64];
    logic [5:0]  zigzag_nat [64];

    coef_beat_t  pending_coefs [$];
    int          failures = 0;
    int          cycles = 0;
    int          hold_request = 0;
    bit          no_idle = 1'b0;

    mpeg1_block_dequantizer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Build the zigzag walk: even diagonals run up, odd diagonals run down
    initial
    begin : zigzag_walk
        int k;
        int lo;
        int hi;
        k = 0;
        for (int s = 0; s < 15; s++)
        begin
            lo = (s > 7) ? s - 7 : 0;
            hi = (s < 7) ? s : 7;
            if (s % 2 == 0)
            begin
                for (int r = hi; r >= lo; r--)
                begin
                    zigzag_nat[k] = 6'(r * 8 + s - r);
                    k++;
                end
            end
            else
            begin
                for (int r = lo; r <= hi; r++)
                begin
                    zigzag_nat[k] = 6'(r * 8 + s - r);
                    k++;
                end
            end
        end
    end

    // Advance the mirrored state by one item; return 1 when a beat is due
    function automatic bit dequantize_item(input blk_item_t it, output coef_beat_t res);
        logic [1:0]         sel;
        logic signed [15:0] diff16;
        logic [15:0]        dc_sum;
        logic [6:0]         pos;
        logic [5:0]         nat;
        int unsigned        lev;
        int unsigned        qs;
        int unsigned        mag;
        res.position = '0;
        res.coefficient = '0;
        res.error = 1'b0;
        case (it.op)
            OP_INTRA_DC:
            begin
                if (it.component < COMP_CB)
                    sel = PRED_LUMA;
                else if (it.component == COMP_CB)
                    sel = PRED_CB;
                else
                    sel = PRED_CR;
                diff16 = it.dc_diff;
                dc_sum = dc_pred[sel] + diff16;
                dc_pred[sel] = dc_sum;
                intra_blk = 1'b1;
                scan_pos = 7'd1;
                res.coefficient = {dc_sum, 3'b000};
                return 1'b1;
            end
            OP_START_NONINTRA:
            begin
                intra_blk = 1'b0;
                scan_pos = '0;
                return 1'b0;
            end
            OP_COEF:
            begin
                pos = scan_pos + it.run;
                // flag and pin the position once the block overruns
                if (pos > 7'd63)
                begin
                    scan_pos = SCAN_END;
                    res.error = 1'b1;
                    return 1'b1;
                end
                nat = zigzag_nat[pos[5:0]];
                lev = it.level_mag;
                qs = it.qscale;
                if (intra_blk)
                    mag = (lev * qs * intra_w[nat]) >> 3;
                else
                    mag = ((2 * lev + 1) * qs * inter_w[nat]) >> 4;
                // force odd, but leave a zero magnitude alone
                if (mag != 0)
                    mag = (mag - 1) | 1;
                if (mag > MAG_LIMIT)
                    mag = MAG_LIMIT;
                scan_pos = pos + 7'd1;
                res.position = nat;
                res.coefficient = 19'(it.level_neg ? (0 - mag) : mag);
                return 1'b1;
            end
            OP_LOAD_INTRA_W:
            begin
                intra_w[it.w_index] = it.w_value;
                return 1'b0;
            end
            OP_LOAD_NONINTRA_W:
            begin
                inter_w[it.w_index] = it.w_value;
                return 1'b0;
            end
            OP_SET_PRED:
            begin
                dc_pred[PRED_LUMA] = it.pred_value;
                dc_pred[PRED_CB] = it.pred_value;
                dc_pred[PRED_CR] = it.pred_value;
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic blk_item_t rand_item(input logic [2:0] op);
        blk_item_t it;
        it.op = op;
        it.component = 3'($urandom);
        it.dc_diff = 9'($urandom);
        it.run = 6'($urandom);
        it.level_mag = 9'($urandom);
        it.level_neg = 1'($urandom);
        it.qscale = 5'($urandom);
        it.w_index = 6'($urandom);
        it.w_value = 8'($urandom);
        it.pred_value = 16'($urandom);
        return it;
    endfunction

    // Mostly short runs and modest levels, with the odd wide one
    function automatic blk_item_t rand_coef();
        blk_item_t it;
        it = rand_item(OP_COEF);
        if ($urandom_range(9) != 0)
            it.run = 6'($urandom_range(2));
        if ($urandom_range(3) != 0)
            it.level_mag = 9'($urandom_range(1, 40));
        if (it.qscale == 0 && $urandom_range(15) != 0)
            it.qscale = 5'd1;
        return it;
    endfunction

    // Offer one beat, wait for the handshake, then log what it should yield
    task automatic send_beat(input blk_item_t it);
        coef_beat_t res;
        if (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {1'b0, it.pred_value, it.w_value, it.w_index, it.qscale,
                          it.level_neg, it.level_mag, it.run, it.dc_diff, it.component};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (dequantize_item(it, res))
            pending_coefs.push_back(res);
    endtask

    task automatic send_coef(input int run, input int lev, input bit neg, input int qs);
        blk_item_t it;
        it = rand_item(OP_COEF);
        it.run = 6'(run);
        it.level_mag = 9'(lev);
        it.level_neg = neg;
        it.qscale = 5'(qs);
        send_beat(it);
    endtask

    task automatic send_dc(input logic [2:0] comp, input int diff);
        blk_item_t it;
        it = rand_item(OP_INTRA_DC);
        it.component = comp;
        it.dc_diff = 9'(diff);
        send_beat(it);
    endtask

    task automatic send_pred(input logic signed [15:0] value);
        blk_item_t it;
        it = rand_item(OP_SET_PRED);
        it.pred_value = value;
        send_beat(it);
    endtask

    // Fill both weight matrices, extremes at the corners, a zero weight at index 2
    task automatic test_weight_load();
        blk_item_t it;
        for (int i = 0; i < 128; i++)
        begin
            it = rand_item(i < 64 ? OP_LOAD_INTRA_W : OP_LOAD_NONINTRA_W);
            it.w_index = 6'(i);
            if (it.w_index == 0)
                it.w_value = 8'd255;
            else if (it.w_index == 63)
                it.w_value = 8'd1;
            else if (it.w_index == 2)
                it.w_value = 8'd0;
            send_beat(it);
        end
    endtask

    // No block started yet: non-intra scaling from scan position zero
    task automatic test_reset_state();
        send_coef(0, 1, 1'b0, 1);
        send_coef(62, 256, 1'b1, 31);
        send_coef(0, 3, 1'b0, 5);
        send_coef(0, 3, 1'b0, 5);
    endtask

    task automatic test_dc_predictors();
        send_dc(3'd0, 255);
        send_dc(COMP_CB, -256);
        send_dc(COMP_CR, 1);
        send_dc(3'd7, -1);
        send_dc(3'd6, 0);
        send_dc(3'd3, -255);
        // wrap each predictor across its 16-bit range
        send_pred(16'sh7FFF);
        send_dc(3'd2, 255);
        send_pred(-16'sh8000);
        send_dc(COMP_CB, -256);
        send_dc(COMP_CR, -1);
    endtask

    task automatic test_coefficients();
        blk_item_t it;
        it = rand_item(OP_LOAD_INTRA_W);
        it.w_index = 6'd1;
        it.w_value = 8'd255;
        send_beat(it);
        it = rand_item(OP_LOAD_NONINTRA_W);
        it.w_index = 6'd1;
        it.w_value = 8'd255;
        send_beat(it);
        // intra block: saturation, zero level, small value
        send_dc(3'd1, 0);
        send_coef(0, 511, 1'b1, 31);
        send_coef(0, 0, 1'b0, 31);
        send_coef(5, 1, 1'b1, 1);
        // non-intra block: saturation, zero scale, overrun
        it = rand_item(OP_START_NONINTRA);
        send_beat(it);
        send_coef(1, 511, 1'b0, 31);
        send_coef(0, 0, 1'b1, 0);
        send_coef(63, 1, 1'b0, 1);
        // reserved codes must leave the overrun state in place
        send_beat(rand_item(OP_RESERVED_6));
        send_beat(rand_item(OP_RESERVED_7));
        send_coef(0, 2, 1'b0, 2);
    endtask

    // Hold the output while a dense run of coefficients piles up behind it
    task automatic test_backpressure();
        no_idle = 1'b1;
        hold_request = HOLD_CYCLES;
        send_dc(COMP_CB, 17);
        repeat (24)
            send_beat(rand_coef());
        no_idle = 1'b0;
    endtask

    task automatic test_random_blocks();
        blk_item_t it;
        int        sent;
        int        len;
        int        pick;
        sent = 0;
        no_idle = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= STEADY_ITEMS)
                no_idle = 1'b0;
            pick = $urandom_range(99);
            if (pick < 6)
            begin
                // ignored by the block, so not counted
                send_beat(rand_item($urandom_range(1) ? OP_RESERVED_6 : OP_RESERVED_7));
            end
            else if (pick < 12)
            begin
                send_beat(rand_item($urandom_range(1) ? OP_LOAD_INTRA_W : OP_LOAD_NONINTRA_W));
                sent++;
            end
            else if (pick < 16)
            begin
                send_beat(rand_item(OP_SET_PRED));
                sent++;
            end
            else if (pick < 20)
            begin
                // stray coefficient continuing whatever block is open
                send_beat(rand_coef());
                sent++;
            end
            else
            begin
                it = rand_item($urandom_range(99) < 60 ? OP_INTRA_DC : OP_START_NONINTRA);
                send_beat(it);
                sent++;
                len = ($urandom_range(7) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 12);
                repeat (len)
                begin
                    send_beat(rand_coef());
                    sent++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Compare each output beat with the oldest pending coefficient
    initial
    begin : coef_sink
        coef_beat_t oldest;
        int         hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (pending_coefs.size() == 0)
                begin
                    $error("unexpected beat: position %0d coefficient %0d error %0d",
                           m_axis_tdata[5:0], $signed(m_axis_tdata[24:6]), m_axis_tuser[0]);
                    failures++;
                end
                else
                begin
                    oldest = pending_coefs.pop_front();
                    if (m_axis_tdata[5:0] !== oldest.position)
                    begin
                        $error("position: expected %0d, actual %0d",
                               oldest.position, m_axis_tdata[5:0]);
                        failures++;
                    end
                    if (m_axis_tdata[24:6] !== oldest.coefficient)
                    begin
                        $error("coefficient: expected %0d, actual %0d",
                               oldest.coefficient, $signed(m_axis_tdata[24:6]));
                        failures++;
                    end
                    if (m_axis_tuser[0] !== oldest.error)
                    begin
                        $error("error: expected %0d, actual %0d",
                               oldest.error, m_axis_tuser[0]);
                        failures++;
                    end
                end
            end
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL mpeg1_block_dequantizer");
            $finish;
        end
    end

    initial
    begin : run_tests
        for (int i = 0; i < 3; i++)
            dc_pred[i] = '0;
        scan_pos = '0;
        intra_blk = 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_weight_load();
        test_reset_state();
        test_dc_predictors();
        test_coefficients();
        test_backpressure();
        test_random_blocks();
        s_axis_tvalid <= 1'b0;
        // drain, then give the pipeline time to show any extra beat
        while (pending_coefs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (failures == 0)
            $display("PASS mpeg1_block_dequantizer");
        else
            $display("FAIL mpeg1_block_dequantizer");
        $finish;
    end

endmodule
